>>> hdl/uart_command_line_assembler_macros.svh
// Assertion helpers shared by the line assembler.
`ifndef UART_COMMAND_LINE_ASSEMBLER_MACROS_SVH
`define UART_COMMAND_LINE_ASSEMBLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UCLA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line assembler check failed");

// Next-cycle implication, checked out of reset.
`define UCLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line assembler check failed");

`endif

>>> hdl/ucla_pkg.sv
package ucla_pkg;

  localparam int LINE_MAX_DEF = 96;
  localparam int LEN_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int IDX_W        = 7;

  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_IDLE    = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RELEASE = 2'd3
  } act_e;

  // Result fields of one beat, apart from the read data that the store returns.
  typedef struct packed {
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
    logic             line_closed;
    logic             rd_en;
  } res_t;

endpackage

>>> hdl/ucla_ram.sv
module ucla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 95,
  parameter int AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ucla_ctrl.sv
module ucla_ctrl #(
  parameter int LINE_MAX = ucla_pkg::LINE_MAX_DEF,
  parameter int AW       = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  ucla_pkg::act_e              action_i,
  input  logic [ucla_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [ucla_pkg::IDX_W-1:0]  read_index_i,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [ucla_pkg::BYTE_W-1:0] wdata_o,
  output logic [AW-1:0]               raddr_o,
  output ucla_pkg::res_t              res_o
);

  localparam logic [ucla_pkg::LEN_W-1:0] FillLast = ucla_pkg::LEN_W'(LINE_MAX - 1);

  logic [ucla_pkg::LEN_W-1:0] fill_q, fill_d;
  logic [ucla_pkg::LEN_W-1:0] done_q, done_d;
  logic                       ready_q, ready_d;
  logic                       close_ok;
  logic                       closed;
  logic                       rd_en;
  logic                       wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      done_q  <= '0;
      ready_q <= 1'b0;
    end else if (fire_i) begin
      fill_q  <= fill_d;
      done_q  <= done_d;
      ready_q <= ready_d;
    end
  end

  assign close_ok = (fill_q != '0) && !ready_q;

  always_comb begin
    fill_d  = fill_q;
    done_d  = done_q;
    ready_d = ready_q;
    closed  = 1'b0;
    rd_en   = 1'b0;
    wr      = 1'b0;
    case (action_i)
      ucla_pkg::ACT_BYTE: begin
        if (rx_byte_i == ucla_pkg::CH_LF) begin
          // A newline restarts the fill even when it cannot close a line.
          fill_d = '0;
          if (close_ok) begin
            closed  = 1'b1;
            ready_d = 1'b1;
            done_d  = fill_q;
          end
        end else if (rx_byte_i != ucla_pkg::CH_CR && rx_byte_i != ucla_pkg::CH_NUL
                     && !ready_q) begin
          if (fill_q < FillLast) begin
            wr     = 1'b1;
            fill_d = fill_q + 1'b1;
          end else begin
            // Overlong line: throw it away and start over.
            fill_d = '0;
          end
        end
      end
      ucla_pkg::ACT_IDLE: begin
        if (close_ok) begin
          closed  = 1'b1;
          ready_d = 1'b1;
          done_d  = fill_q;
          fill_d  = '0;
        end
      end
      ucla_pkg::ACT_READ: begin
        rd_en = ready_q && (read_index_i < done_q);
      end
      ucla_pkg::ACT_RELEASE: begin
        ready_d = 1'b0;
        done_d  = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  assign we_o    = fire_i && wr;
  assign waddr_o = fill_q[AW-1:0];
  assign wdata_o = rx_byte_i;
  assign raddr_o = read_index_i[AW-1:0];

  assign res_o.line_ready  = ready_d;
  assign res_o.line_length = ready_d ? done_d : '0;
  assign res_o.line_closed = closed;
  assign res_o.rd_en       = rd_en;

endmodule

>>> hdl/uart_command_line_assembler.sv
// Flow: an accepted beat moves from the input register to the result register.
// Throughput: one beat per cycle while the result side is not stalled; the input
// register and the result register each advance whenever the side behind them
// is free, and the store is one RAM.
// Reset: asynchronous, active low; clears the fill count, the ready flag, the
// latched length and both valid flags. Line store contents stay undefined.
`include "uart_command_line_assembler_macros.svh"

module uart_command_line_assembler #(
  parameter int LINE_MAX = ucla_pkg::LINE_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [ucla_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [ucla_pkg::IDX_W-1:0]  read_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        line_ready_o,
  output logic [ucla_pkg::LEN_W-1:0]  line_length_o,
  output logic [ucla_pkg::BYTE_W-1:0] read_data_o,
  output logic                        line_closed_o
);

  localparam int StoreDepth = LINE_MAX - 1;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic                        in_valid_q;
  ucla_pkg::act_e              action_q;
  logic [ucla_pkg::BYTE_W-1:0] rx_byte_q;
  logic [ucla_pkg::IDX_W-1:0]  read_index_q;
  logic                        out_valid_q;
  ucla_pkg::res_t              res_q, res_d;
  logic                        out_free;
  logic                        fire;
  logic                        in_take;
  logic                        we;
  logic [AddrW-1:0]            waddr;
  logic [AddrW-1:0]            raddr;
  logic [ucla_pkg::BYTE_W-1:0] wdata;
  logic [ucla_pkg::BYTE_W-1:0] rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take || fire) begin
        in_valid_q <= in_take;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q     <= ucla_pkg::act_e'(action_i);
      rx_byte_q    <= rx_byte_i;
      read_index_q <= read_index_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  ucla_ctrl #(
    .LINE_MAX (LINE_MAX),
    .AW       (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .action_i     (action_q),
    .rx_byte_i    (rx_byte_q),
    .read_index_i (read_index_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_o      (raddr),
    .res_o        (res_d)
  );

  // The read register only loads on a read beat, so it holds while the result stalls.
  ucla_ram #(
    .WIDTH (ucla_pkg::BYTE_W),
    .DEPTH (StoreDepth),
    .AW    (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (fire && res_d.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign line_ready_o  = res_q.line_ready;
  assign line_length_o = res_q.line_length;
  assign line_closed_o = res_q.line_closed;
  assign read_data_o   = res_q.rd_en ? rdata : '0;

  `UCLA_ASSERT_IMPL(a_len_zero_idle, out_valid_o && !line_ready_o, line_length_o == '0)
  `UCLA_ASSERT_IMPL(a_closed_ready, out_valid_o && line_closed_o, line_ready_o)
  `UCLA_ASSERT_IMPL(a_data_needs_line, out_valid_o && (read_data_o != '0), line_ready_o)
  `UCLA_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

endmodule
